/* rtl/udp_ipv4_frame_header_builder_core_defines.svh */
// Assertion macros for the UDP/IPv4 header builder.
// Taken in by the checker file; needs nothing else.
`ifndef UDP_IPV4_FRAME_HEADER_BUILDER_CORE_DEFINES_SVH
`define UDP_IPV4_FRAME_HEADER_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define UDPHB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("header stream check failed");

// Next-cycle implication, held off during reset
`define UDPHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("header stream sequence check failed");

`endif

/* rtl/udphb_pkg.sv */
// Shared types, constants and checksum helpers for the UDP/IPv4 header builder.
// No dependencies; the RTL modules refer to it by scoped names, the testbench files import it.
package udphb_pkg;

	localparam int MAX_PAYLOAD_DEF = 1472;
	localparam int LEN_W           = 11;
	localparam int HDR_LEN         = 42;
	localparam int IDX_W           = 6;
	localparam int SUM_W           = 20;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 48;

	localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);

	localparam logic [15:0] IDENT_RESET     = 16'h1489;
	localparam logic [7:0]  DEST_HOST_RESET = 8'd254;
	localparam logic [15:0] IP_UDP_HDR_LEN  = 16'd28;
	localparam logic [15:0] UDP_HDR_LEN     = 16'd8;

	// Fixed header fields
	localparam logic [47:0] SRC_MAC        = 48'h00E93A25C229;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [7:0]  IP_FLAGS_DF    = 8'h40;
	localparam logic [7:0]  IP_TTL         = 8'h40;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
	localparam logic [7:0]  NET_A          = 8'd192;
	localparam logic [7:0]  NET_B          = 8'd168;
	localparam logic [7:0]  NET_C          = 8'd1;

	// Constant words folded into each checksum up front
	localparam logic [SUM_W-1:0] IP_SUM_CONST = SUM_W'(
		{IP_VER_IHL, 8'h00} + {IP_FLAGS_DF, 8'h00} + {IP_TTL, IP_PROTO_UDP} + {NET_A, NET_B});
	localparam logic [SUM_W-1:0] UDP_SUM_CONST = SUM_W'({NET_A, NET_B} + {8'h00, IP_PROTO_UDP});

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNICAST   = 3'd0,
		REG_DEST_MAC  = 3'd1,
		REG_DEST_HOST = 3'd2,
		REG_OWN_HOST  = 3'd3,
		REG_SRC_PORT  = 3'd4,
		REG_DST_PORT  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        unicast_mode;
		logic [47:0] dest_mac;
		logic [7:0]  dest_host_octet;
		logic [7:0]  own_host_octet;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       eop;
	} pay_item_t;

	typedef struct packed {
		logic [7:0]       header_byte;
		logic [IDX_W-1:0] header_index;
		logic             oversize;
		logic             last_out;
	} hdr_item_t;

	// Everything a finished frame hands to the header side
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [15:0]      sum;
		logic [15:0]      tail;
		logic             ovf;
		logic [15:0]      ident;
	} frame_t;

	// One's-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Fold a wide plain sum back to 16 bits, end-around
	function automatic logic [15:0] oc_fold(input logic [SUM_W-1:0] raw);
		logic [16:0] f;
		f = {1'b0, raw[15:0]} + 17'(raw[SUM_W-1:16]);
		return f[15:0] + {15'd0, f[16]};
	endfunction

endpackage

/* rtl/udphb_stream_if.sv */
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is set per instance; no other dependencies.
interface udphb_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/udphb_accum.sv */
// Payload side: counts bytes, folds the one's-complement sum, tracks ident.
// Depends on udphb_pkg.
module udphb_accum #(
	parameter int MaxPayload = udphb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  udphb_pkg::pay_item_t in_item,
	output logic                frm_valid,
	input  logic                frm_take,
	output udphb_pkg::frame_t   frm
);

	localparam int CNT_W = $clog2(MaxPayload + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MaxPayload);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [15:0]      sum_q, sum_n;
	logic [7:0]       held_q, held_n;
	logic             odd_q, odd_n;
	logic             ovf_q, ovf_n;
	logic [15:0]      ident_q;
	logic             frm_valid_q;
	udphb_pkg::frame_t frm_q;
	logic             in_fire, frame_end;

	// One frame may wait here while the header side is busy
	assign in_ready  = !frm_valid_q || frm_take;
	assign in_fire   = in_valid && in_ready;
	assign frame_end = in_fire && in_item.eop;
	assign frm_valid = frm_valid_q;
	assign frm       = frm_q;

	// Next accumulator state for the incoming byte
	always_comb begin
		cnt_n  = cnt_q;
		sum_n  = sum_q;
		held_n = held_q;
		odd_n  = odd_q;
		ovf_n  = ovf_q;
		if (in_fire) begin
			if (cnt_q >= CNT_MAX) begin
				ovf_n = 1'b1;
			end else begin
				cnt_n = cnt_q + 1'b1;
				if (odd_q) begin
					sum_n = udphb_pkg::oc_add(sum_q, {held_q, in_item.payload_byte});
					odd_n = 1'b0;
				end else begin
					held_n = in_item.payload_byte;
					odd_n  = 1'b1;
				end
			end
		end
	end

	// Accumulator and identification registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_q       <= '0;
			held_q      <= '0;
			odd_q       <= 1'b0;
			ovf_q       <= 1'b0;
			ident_q     <= udphb_pkg::IDENT_RESET;
			frm_valid_q <= 1'b0;
		end else begin
			if (frame_end) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				held_q  <= '0;
				odd_q   <= 1'b0;
				ovf_q   <= 1'b0;
				ident_q <= ident_q + 16'(cnt_n);
			end else begin
				cnt_q  <= cnt_n;
				sum_q  <= sum_n;
				held_q <= held_n;
				odd_q  <= odd_n;
				ovf_q  <= ovf_n;
			end
			if (frame_end) begin
				frm_valid_q <= 1'b1;
			end else if (frm_take) begin
				frm_valid_q <= 1'b0;
			end
		end
	end

	// Snapshot of the finished frame
	always_ff @(posedge clk) begin
		if (frame_end) begin
			frm_q.len   <= udphb_pkg::LEN_W'(cnt_n);
			frm_q.sum   <= sum_n;
			frm_q.tail  <= odd_n ? {held_n, 8'h00} : 16'h0000;
			frm_q.ovf   <= ovf_n;
			frm_q.ident <= ident_q;
		end
	end

endmodule

/* rtl/udphb_emit.sv */
// Header side: checksum sums, fold and complement, then the 42-byte serialiser.
// Depends on udphb_pkg.
module udphb_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udphb_pkg::cfg_t      cfg,
	input  logic                 frm_valid,
	output logic                 frm_take,
	input  udphb_pkg::frame_t    frm,
	output logic                 out_valid,
	input  logic                 out_ready,
	output udphb_pkg::hdr_item_t out_item
);

	localparam int SW = udphb_pkg::SUM_W;
	localparam int IW = udphb_pkg::IDX_W;

	// Stage 2: raw sums
	logic              v2_q;
	udphb_pkg::frame_t frm_s2;
	logic [SW-1:0]     ip_raw_s2, udp_raw_s2;
	logic [SW-1:0]     ip_raw, udp_raw;

	// Stage 3: serialiser
	logic                         busy_q;
	logic [IW-1:0]                idx_q;
	logic [udphb_pkg::LEN_W-1:0]  len_s3;
	logic [15:0]                  ident_s3, ipck_s3, udpck_s3;
	logic                         ovf_s3;

	logic                 out_valid_q;
	udphb_pkg::hdr_item_t out_item_q;

	logic        load2, move23, out_load;
	logic [47:0] dmac;
	logic [31:0] dip;
	logic [15:0] own_w, tot_len2, udp_len2, tot_len3, udp_len3;
	logic [7:0]  hbyte;

	assign move23    = v2_q && !busy_q;
	assign frm_take  = !v2_q || move23;
	assign load2     = frm_valid && frm_take;
	assign out_load  = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Destination addresses by mode
	always_comb begin
		dmac  = cfg.unicast_mode ? cfg.dest_mac : '1;
		dip   = cfg.unicast_mode ?
			{udphb_pkg::NET_A, udphb_pkg::NET_B, udphb_pkg::NET_C, cfg.dest_host_octet} : '1;
		own_w = {udphb_pkg::NET_C, cfg.own_host_octet};
	end

	// Plain multi-operand sums, folded a stage later
	always_comb begin
		tot_len2 = udphb_pkg::IP_UDP_HDR_LEN + 16'(frm.len);
		udp_len2 = udphb_pkg::UDP_HDR_LEN + 16'(frm.len);
		ip_raw = udphb_pkg::IP_SUM_CONST + SW'(tot_len2) + SW'(frm.ident) + SW'(own_w)
			+ SW'(dip[31:16]) + SW'(dip[15:0]);
		udp_raw = udphb_pkg::UDP_SUM_CONST + SW'(own_w) + SW'(dip[31:16]) + SW'(dip[15:0])
			+ SW'(udp_len2) + SW'(udp_len2) + SW'(cfg.src_port) + SW'(cfg.dst_port)
			+ SW'(frm.sum) + SW'(frm.tail);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load2) begin
				v2_q <= 1'b1;
			end else if (move23) begin
				v2_q <= 1'b0;
			end
			if (move23) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == udphb_pkg::HDR_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (load2) begin
			frm_s2     <= frm;
			ip_raw_s2  <= ip_raw;
			udp_raw_s2 <= udp_raw;
		end
		if (move23) begin
			len_s3   <= frm_s2.len;
			ident_s3 <= frm_s2.ident;
			ovf_s3   <= frm_s2.ovf;
			ipck_s3  <= ~udphb_pkg::oc_fold(ip_raw_s2);
			udpck_s3 <= ~udphb_pkg::oc_fold(udp_raw_s2);
		end
		if (out_load) begin
			out_item_q.header_byte  <= hbyte;
			out_item_q.header_index <= idx_q;
			out_item_q.oversize     <= ovf_s3;
			out_item_q.last_out     <= (idx_q == udphb_pkg::HDR_LAST);
		end
	end

	// Header byte at the current position
	always_comb begin
		tot_len3 = udphb_pkg::IP_UDP_HDR_LEN + 16'(len_s3);
		udp_len3 = udphb_pkg::UDP_HDR_LEN + 16'(len_s3);
		unique case (idx_q)
			6'd0:    hbyte = dmac[47:40];
			6'd1:    hbyte = dmac[39:32];
			6'd2:    hbyte = dmac[31:24];
			6'd3:    hbyte = dmac[23:16];
			6'd4:    hbyte = dmac[15:8];
			6'd5:    hbyte = dmac[7:0];
			6'd6:    hbyte = udphb_pkg::SRC_MAC[47:40];
			6'd7:    hbyte = udphb_pkg::SRC_MAC[39:32];
			6'd8:    hbyte = udphb_pkg::SRC_MAC[31:24];
			6'd9:    hbyte = udphb_pkg::SRC_MAC[23:16];
			6'd10:   hbyte = udphb_pkg::SRC_MAC[15:8];
			6'd11:   hbyte = udphb_pkg::SRC_MAC[7:0];
			6'd12:   hbyte = udphb_pkg::ETHERTYPE_IPV4[15:8];
			6'd13:   hbyte = udphb_pkg::ETHERTYPE_IPV4[7:0];
			6'd14:   hbyte = udphb_pkg::IP_VER_IHL;
			6'd15:   hbyte = 8'h00;
			6'd16:   hbyte = tot_len3[15:8];
			6'd17:   hbyte = tot_len3[7:0];
			6'd18:   hbyte = ident_s3[15:8];
			6'd19:   hbyte = ident_s3[7:0];
			6'd20:   hbyte = udphb_pkg::IP_FLAGS_DF;
			6'd21:   hbyte = 8'h00;
			6'd22:   hbyte = udphb_pkg::IP_TTL;
			6'd23:   hbyte = udphb_pkg::IP_PROTO_UDP;
			6'd24:   hbyte = ipck_s3[15:8];
			6'd25:   hbyte = ipck_s3[7:0];
			6'd26:   hbyte = udphb_pkg::NET_A;
			6'd27:   hbyte = udphb_pkg::NET_B;
			6'd28:   hbyte = udphb_pkg::NET_C;
			6'd29:   hbyte = cfg.own_host_octet;
			6'd30:   hbyte = dip[31:24];
			6'd31:   hbyte = dip[23:16];
			6'd32:   hbyte = dip[15:8];
			6'd33:   hbyte = dip[7:0];
			6'd34:   hbyte = cfg.src_port[15:8];
			6'd35:   hbyte = cfg.src_port[7:0];
			6'd36:   hbyte = cfg.dst_port[15:8];
			6'd37:   hbyte = cfg.dst_port[7:0];
			6'd38:   hbyte = udp_len3[15:8];
			6'd39:   hbyte = udp_len3[7:0];
			6'd40:   hbyte = udpck_s3[15:8];
			6'd41:   hbyte = udpck_s3[7:0];
			default: hbyte = 8'h00;
		endcase
	end

endmodule

/* rtl/udp_ipv4_frame_header_builder_core.sv */
// Top level of the UDP/IPv4 frame header builder.
// Depends on udphb_pkg, udphb_stream_if, udphb_accum and udphb_emit.
//
// payload_ch takes one UDP payload byte per transaction, eop set on the
// final one; header_ch returns the 42-byte Ethernet/IPv4/UDP header, one byte
// per transaction with its index, the oversize flag and last_out on byte 41.
// Payload bytes are taken every cycle unless payload_ch stalls. The first
// header byte is offered once the frame has passed the holding slot, the
// raw-sum stage, the serialiser stage and its output register; bytes then
// follow one per cycle while ready is high. A finished frame goes to a holding
// slot and on into the checksum stage, so two frames can wait behind the
// header being sent; payload_ch stalls only while both are occupied.
// Stalls on header_ch hold the current byte and back up through the stages.
// Bytes beyond MaxPayload are dropped and flag oversize on the whole header.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, by the user
// only while idle; the block does not enforce this. Reset clears all frame
// state, sets the IP identification to 0x1489, loads the register defaults
// (broadcast, destination host 254) and empties the pipeline.
module udp_ipv4_frame_header_builder_core #(
	parameter int MaxPayload = udphb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	udphb_stream_if.sink                          payload_ch,
	udphb_stream_if.source                        header_ch,
	input  logic                                  cfg_we,
	input  logic [udphb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [udphb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	udphb_pkg::cfg_t   cfg_q;
	udphb_pkg::frame_t frm;
	logic              frm_valid, frm_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unicast_mode    <= 1'b0;
			cfg_q.dest_mac        <= '0;
			cfg_q.dest_host_octet <= udphb_pkg::DEST_HOST_RESET;
			cfg_q.own_host_octet  <= '0;
			cfg_q.src_port        <= '0;
			cfg_q.dst_port        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				udphb_pkg::REG_UNICAST:   cfg_q.unicast_mode    <= cfg_wdata[0];
				udphb_pkg::REG_DEST_MAC:  cfg_q.dest_mac        <= cfg_wdata[47:0];
				udphb_pkg::REG_DEST_HOST: cfg_q.dest_host_octet <= cfg_wdata[7:0];
				udphb_pkg::REG_OWN_HOST:  cfg_q.own_host_octet  <= cfg_wdata[7:0];
				udphb_pkg::REG_SRC_PORT:  cfg_q.src_port        <= cfg_wdata[15:0];
				udphb_pkg::REG_DST_PORT:  cfg_q.dst_port        <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Payload accumulation
	udphb_accum #(
		.MaxPayload(MaxPayload)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (payload_ch.valid),
		.in_ready  (payload_ch.ready),
		.in_item   (payload_ch.payload),
		.frm_valid (frm_valid),
		.frm_take  (frm_take),
		.frm       (frm)
	);

	// Checksums and header serialiser
	udphb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.frm_valid (frm_valid),
		.frm_take  (frm_take),
		.frm       (frm),
		.out_valid (header_ch.valid),
		.out_ready (header_ch.ready),
		.out_item  (header_ch.payload)
	);

endmodule

/* rtl/udphb_checker.sv */
// Port-level checks on the header stream of the UDP/IPv4 header builder.
// Depends on udphb_pkg and the defines header; bound to the top level below.
`include "udp_ipv4_frame_header_builder_core_defines.svh"

module udphb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  out_byte,
	input logic [udphb_pkg::IDX_W-1:0] out_index,
	input logic                        out_oversize,
	input logic                        out_last
);

	// last_out marks exactly the final header position
	`UDPHB_ASSERT_SAME(a_last_pos, clk, arst_n, out_valid, (out_last == (out_index == udphb_pkg::HDR_LAST)))

	// No index past the end of the header
	`UDPHB_ASSERT_SAME(a_index_range, clk, arst_n, out_valid, (out_index <= udphb_pkg::HDR_LAST))

	// Within a run the next byte follows at once, one place on, same oversize flag
	`UDPHB_ASSERT_NEXT(a_run_cont, clk, arst_n, (out_valid && out_ready && !out_last), (out_valid && (out_index == $past(out_index) + 1'b1) && (out_oversize == $past(out_oversize))))

	// A stalled transaction holds
	`UDPHB_ASSERT_NEXT(a_stall_hold, clk, arst_n, (out_valid && !out_ready), (out_valid && $stable(out_byte) && $stable(out_index)))

endmodule

bind udp_ipv4_frame_header_builder_core udphb_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (header_ch.valid),
	.out_ready    (header_ch.ready),
	.out_byte     (header_ch.payload.header_byte),
	.out_index    (header_ch.payload.header_index),
	.out_oversize (header_ch.payload.oversize),
	.out_last     (header_ch.payload.last_out)
);

/* dv/udphb_header_checker.sv */
`timescale 1ns / 1ps
// Header checker for the UDP/IPv4 frame header builder: mirrors the registers,
// predicts each 42-byte header from the accepted payload and compares results.
// Depends on udphb_pkg for the channel item types and register indexes.
module udphb_header_checker #(
	parameter int MaxPayload = udphb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pay_valid,
	input  logic                                 pay_ready,
	input  udphb_pkg::pay_item_t                 pay_item,
	input  logic                                 hdr_valid,
	input  logic                                 hdr_ready,
	input  udphb_pkg::hdr_item_t                 hdr_item,
	input  logic                                 cfg_we,
	input  logic [udphb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [udphb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                   errors,
	output int                                   pending,
	output int                                   checked
);
	import udphb_pkg::*;

	localparam logic [47:0] OWN_MAC       = 48'h00E93A25C229;
	localparam logic [15:0] START_IDENT   = 16'h1489;
	localparam logic [7:0]  START_DHOST   = 8'd254;
	localparam logic [23:0] SUBNET        = {8'd192, 8'd168, 8'd1};
	localparam int          REPORT_LIMIT  = 10;

	// Register mirror and running frame state
	cfg_t        regs;
	logic [15:0] pay_sum;
	logic [7:0]  high_byte;
	logic        half_word;
	logic [10:0] pay_len;
	logic [15:0] ident;
	logic        truncated;

	hdr_item_t   hdr_expected_q[$];
	hdr_item_t   want;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] s;
		s = 32'(a) + 32'(b);
		return 16'(s[15:0] + s[31:16]);
	endfunction

	// Build the full header for the frame just closed and queue its bytes
	function automatic void queue_header();
		logic [8*42-1:0] frame;
		logic [15:0]     udp_len;
		logic [15:0]     acc;
		logic [47:0]     dst_mac;
		logic [31:0]     dst_ip;
		hdr_item_t       it;
		int              p;
		udp_len = 16'd8 + 16'(pay_len);
		dst_mac = regs.unicast_mode ? regs.dest_mac : '1;
		dst_ip  = regs.unicast_mode ? {SUBNET, regs.dest_host_octet} : '1;
		frame = {dst_mac, OWN_MAC, 16'h0800, 8'h45, 8'h00, udp_len + 16'd20, ident,
			8'h40, 8'h00, 8'h40, 8'h11, 16'h0000, SUBNET, regs.own_host_octet, dst_ip,
			regs.src_port, regs.dst_port, udp_len, 16'h0000};
		// IPv4 header checksum over the 20 header bytes
		acc = 16'h0000;
		for (p = 14; p < 34; p += 2)
			acc = ones_add(acc, frame[335-8*p -: 16]);
		frame[335-8*24 -: 16] = ~acc;
		// UDP checksum: pseudo header, UDP header, payload (odd byte padded)
		acc = 16'h0000;
		for (p = 26; p < 34; p += 2)
			acc = ones_add(acc, frame[335-8*p -: 16]);
		acc = ones_add(acc, 16'h0011);
		acc = ones_add(acc, udp_len);
		for (p = 34; p < 42; p += 2)
			acc = ones_add(acc, frame[335-8*p -: 16]);
		acc = ones_add(acc, pay_sum);
		if (half_word)
			acc = ones_add(acc, {high_byte, 8'h00});
		frame[335-8*40 -: 16] = ~acc;
		for (p = 0; p < 42; p++) begin
			it.header_byte  = frame[335-8*p -: 8];
			it.header_index = IDX_W'(p);
			it.oversize     = truncated;
			it.last_out     = (p == 41);
			hdr_expected_q.push_back(it);
		end
	endfunction

	// Fold one accepted payload byte in; close the frame on its last byte
	function automatic void take_byte(input pay_item_t pi);
		if (pay_len >= 11'(MaxPayload)) begin
			truncated = 1'b1;
		end else begin
			pay_len = pay_len + 11'd1;
			if (half_word) begin
				pay_sum   = ones_add(pay_sum, {high_byte, pi.payload_byte});
				half_word = 1'b0;
			end else begin
				high_byte = pi.payload_byte;
				half_word = 1'b1;
			end
		end
		if (pi.eop) begin
			queue_header();
			ident     = ident + 16'(pay_len);
			pay_sum   = '0;
			high_byte = '0;
			half_word = 1'b0;
			pay_len   = '0;
			truncated = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs                 = '0;
			regs.dest_host_octet = START_DHOST;
			pay_sum              = '0;
			high_byte            = '0;
			half_word            = 1'b0;
			pay_len              = '0;
			truncated            = 1'b0;
			ident                = START_IDENT;
			hdr_expected_q.delete();
			errors  = 0;
			checked = 0;
		end else begin
			// Register writes, masked to each register's width
			if (cfg_we) begin
				case (cfg_index)
					REG_UNICAST:   regs.unicast_mode    = cfg_wdata[0];
					REG_DEST_MAC:  regs.dest_mac        = cfg_wdata[47:0];
					REG_DEST_HOST: regs.dest_host_octet = cfg_wdata[7:0];
					REG_OWN_HOST:  regs.own_host_octet  = cfg_wdata[7:0];
					REG_SRC_PORT:  regs.src_port        = cfg_wdata[15:0];
					REG_DST_PORT:  regs.dst_port        = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (pay_valid && pay_ready)
				take_byte(pay_item);
			// Compare each header transaction with the oldest prediction
			if (hdr_valid && hdr_ready) begin
				checked++;
				if (hdr_expected_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("header byte %02h (index %0d) arrived with nothing predicted",
							hdr_item.header_byte, hdr_item.header_index);
				end else begin
					want = hdr_expected_q.pop_front();
					if (hdr_item.header_byte !== want.header_byte ||
						hdr_item.header_index !== want.header_index ||
						hdr_item.oversize !== want.oversize ||
						hdr_item.last_out !== want.last_out) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("header mismatch: exp byte %02h idx %0d ovs %0b last %0b, %s",
								want.header_byte, want.header_index, want.oversize,
								want.last_out,
								$sformatf("got byte %02h idx %0d ovs %0b last %0b",
									hdr_item.header_byte, hdr_item.header_index,
									hdr_item.oversize, hdr_item.last_out));
					end
				end
			end
		end
		pending = hdr_expected_q.size();
	end

endmodule

/* dv/udp_ipv4_frame_header_builder_core_test.sv */
`timescale 1ns / 1ps
// Top of the header builder testbench: clock, reset, payload and register
// stimulus, header back-pressure and the verdict. Uses udphb_pkg, udphb_stream_if,
// the block itself and udphb_header_checker.
module udp_ipv4_frame_header_builder_core_test;
	import udphb_pkg::*;

	localparam int MAX_LEN       = MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int ITEM_TARGET   = 460;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	udphb_stream_if #(.item_t(pay_item_t)) pay_ch ();
	udphb_stream_if #(.item_t(hdr_item_t)) hdr_ch ();

	int fail_count;
	int pending;
	int checked;
	int cycle_cnt = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int settings_used = 0;
	int burst_left = 0;

	logic [15:0] stall_pat;
	int          pat_age;

	udp_ipv4_frame_header_builder_core #(.MaxPayload(MAX_LEN)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload_ch (pay_ch),
		.header_ch  (hdr_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	udphb_header_checker #(.MaxPayload(MAX_LEN)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay_valid (pay_ch.valid),
		.pay_ready (pay_ch.ready),
		.pay_item  (pay_ch.payload),
		.hdr_valid (hdr_ch.valid),
		.hdr_ready (hdr_ch.ready),
		.hdr_item  (hdr_ch.payload),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("udp_ipv4_frame_header_builder_core_test NOT OK");
				$finish;
			end
		end
	end

	// Header receiver: stall pattern reloaded now and then, sometimes solid ready
	initial begin
		hdr_ch.ready <= 1'b0;
		pat_age = 0;
		forever begin
			@(posedge clk);
			if (pat_age == 0) begin
				stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
				pat_age   = $urandom_range(16, 96);
			end
			pat_age--;
			hdr_ch.ready <= stall_pat[pat_age % 16];
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// One payload transaction, with burst/gap idling in front of it
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				pay_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pay_ch.valid   <= 1'b1;
		pay_ch.payload <= '{payload_byte: b, eop: lst};
		@(posedge clk);
		while (!pay_ch.ready) @(posedge clk);
		bytes_sent++;
		if (lst)
			frames_sent++;
	endtask

	task automatic send_frame(input int len);
		int          k;
		logic [7:0]  b;
		for (k = 0; k < len; k++) begin
			case ($urandom_range(0, 7))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, k == len - 1);
		end
	endtask

	// Stop sending and wait until every predicted header byte is back
	task automatic wait_idle();
		pay_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	// Full register set; raw values carry junk above each register's width
	task automatic load_settings(input logic [47:0] uni, input logic [47:0] mac,
		input logic [47:0] dhost, input logic [47:0] ohost,
		input logic [47:0] sport, input logic [47:0] dport);
		wait_idle();
		write_reg(REG_UNICAST, uni);
		write_reg(REG_DEST_MAC, mac);
		write_reg(REG_DEST_HOST, dhost);
		write_reg(REG_OWN_HOST, ohost);
		write_reg(REG_SRC_PORT, sport);
		write_reg(REG_DST_PORT, dport);
		write_reg(REG_UNUSED, rand48());
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic load_random_settings();
		load_settings(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		pay_ch.valid   <= 1'b0;
		pay_ch.payload <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_UNICAST;
		cfg_wdata      <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Reset defaults: broadcast, own host 0, ports 0. Payload word 3E32 brings
		// the UDP sum to all ones, so its checksum goes out as zero.
		send_byte(8'h3E, 1'b0);
		send_byte(8'h32, 1'b1);
		// Shortest frame, odd length
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Every register at its top value
		load_settings('1, '1, '1, '1, '1, '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h7F, 1'b1);

		// Unicast to an all-zero MAC and host 0, own host 255
		load_settings(48'd1, 48'd0, 48'd0, 48'd255, 48'd0, 48'hFFFF);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'h01, 1'b1);

		// Random frames, mostly short; back-to-back tiny ones fill the holding slots
		load_random_settings();
		while (bytes_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0:               len = $urandom_range(41, 200);
				1, 2, 3, 4, 5:   len = $urandom_range(9, 40);
				default:         len = $urandom_range(1, 8);
			endcase
			if (len > ITEM_TARGET - bytes_sent)
				len = ITEM_TARGET - bytes_sent;
			send_frame(len);
			if ($urandom_range(0, 7) == 0)
				load_random_settings();
			else if ($urandom_range(0, 9) == 0)
				wait_idle();
		end

		pay_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d payload bytes in %0d frames under %0d register settings",
			bytes_sent, frames_sent, settings_used);
		$display("%0d header bytes compared, incl. broadcast, unicast and zero checksum",
			checked);
		if (fail_count == 0)
			$display("udp_ipv4_frame_header_builder_core_test OK");
		else
			$display("udp_ipv4_frame_header_builder_core_test NOT OK");
		$finish;
	end

endmodule
